/* rtl/core/msd_pkg.sv */
// Shared types and constants for the mean square displacement block.
// Used by every module under rtl/core but msd_ram; depends on nothing else.
package msd_pkg;

  localparam int MSD_MAX_PARTICLES = 1024;

  localparam int INDEX_W   = 10;
  localparam int POS_W     = 32;
  localparam int BOX_W     = 31;
  localparam int COUNT_W   = 11;
  localparam int SUM_W     = 64;
  localparam int OUT_W     = 63;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam int AXES = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

  typedef enum logic {
    KIND_RECORD  = 1'b0,
    KIND_MEASURE = 1'b1
  } msd_kind_t;

  typedef struct packed {
    msd_kind_t          kind;
    logic               in_range;
    logic [INDEX_W-1:0] index;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic               last;
  } msd_cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } msd_qstat_t;

endpackage

/* rtl/core/mean_square_displacement.sv */
// Top level of the mean square displacement block with minimum-image correction.
// Depends on msd_pkg, msd_front, msd_back (and through it msd_ram, msd_div).
//
//   Channel   Handshake               Payload
//   input     start, busy             action, index, pos_x, pos_y, pos_z, last
//   result    done (one-cycle strobe) mean_square, count_mismatch
//   config    cfg_we                  cfg_index, cfg_data
//
// A two-entry queue takes items while the back end works; busy rises when it is full.
// A record item is stored as it is popped; a measure item is paced by the one shared
// 32x32 multiplier that squares the three axes in turn (skipped if its slot is out of range).
// A measure item marked last then runs the bit-serial divider, after which done pulses.
// Reset clears the control state, box sizes and counters; the reference store is not cleared.
// The receiver cannot stall: each result is flagged by done for exactly one cycle.
module mean_square_displacement
  import msd_pkg::*;
#(
  parameter int MAX_PARTICLES = MSD_MAX_PARTICLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action,
  input  logic [INDEX_W-1:0]   index,
  input  logic [POS_W-1:0]     pos_x,
  input  logic [POS_W-1:0]     pos_y,
  input  logic [POS_W-1:0]     pos_z,
  input  logic                 last,
  output logic                 done,
  output logic [OUT_W-1:0]     mean_square,
  output logic                 count_mismatch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOX_W-1:0]     cfg_data
);

  logic       cmd_valid;
  logic       cmd_pop;
  msd_cmd_t   cmd;
  msd_qstat_t qstat;

  assign busy = qstat.full;

  msd_front #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .index     (index),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .last      (last),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .qstat     (qstat)
  );

  msd_back #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .done           (done),
    .mean_square    (mean_square),
    .count_mismatch (count_mismatch)
  );

`ifndef SYNTHESIS
  // Results are separated by the full division, so the strobe never repeats.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe held for two cycles");

  // The queue never holds more items than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  // An accepted item is in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (qstat.count != '0))
    else $error("accepted item missing from queue");

  // The back end pops only what the queue holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("pop from an empty queue");
`endif

endmodule

/* rtl/core/msd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/msd_front.sv */
// Front end: takes items from the command port, classifies them and queues them.
// Depends on msd_pkg.
module msd_front
  import msd_pkg::*;
#(
  parameter int MAX_PARTICLES = MSD_MAX_PARTICLES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               action,
  input  logic [INDEX_W-1:0] index,
  input  logic [POS_W-1:0]   pos_x,
  input  logic [POS_W-1:0]   pos_y,
  input  logic [POS_W-1:0]   pos_z,
  input  logic               last,
  input  logic               cmd_pop,
  output logic               cmd_valid,
  output msd_cmd_t           cmd,
  output msd_qstat_t         qstat
);

  localparam logic [16:0] LIMIT = 17'(MAX_PARTICLES);

  msd_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  logic              full;
  logic              push;
  msd_cmd_t          incoming;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign push      = start && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[head];
  assign qstat     = '{count: count, full: full};

  always_comb begin
    incoming.kind     = action ? KIND_MEASURE : KIND_RECORD;
    incoming.in_range = ({7'b0, index} < LIMIT);
    incoming.index    = index;
    incoming.pos_x    = pos_x;
    incoming.pos_y    = pos_y;
    incoming.pos_z    = pos_z;
    incoming.last     = last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (cmd_pop) begin
        head <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/msd_div.sv */
// Bit-serial restoring divider: 64-bit dividend by 11-bit divisor.
// Depends on msd_pkg.
module msd_div
  import msd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [SUM_W-1:0]   quotient
);

  logic [SUM_W-1:0]     work;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [COUNT_W:0]     trial;
  logic                 fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial    = {rem, work[SUM_W-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(DIV_STEPS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (running) begin
      work <= {work[SUM_W-2:0], fits};
      rem  <= fits ? COUNT_W'(trial - {1'b0, dvs}) : trial[COUNT_W-1:0];
    end
  end

endmodule

/* rtl/core/msd_back.sv */
// Back end: reference store, minimum-image displacement, squaring, accumulation
// and the final division. Depends on msd_pkg, msd_ram and msd_div.
module msd_back
  import msd_pkg::*;
#(
  parameter int MAX_PARTICLES = MSD_MAX_PARTICLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOX_W-1:0]     cfg_data,
  input  logic                 cmd_valid,
  input  msd_cmd_t             cmd,
  output logic                 cmd_pop,
  output logic                 done,
  output logic [OUT_W-1:0]     mean_square,
  output logic                 count_mismatch
);

  localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int RAM_W = AXES * POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CORR,
    S_MUL,
    S_ACC,
    S_FIN,
    S_DIV
  } state_t;

  state_t               state;
  logic [BOX_W-1:0]     box [AXES];
  logic [POS_W-1:0]     cur_pos [AXES];
  logic                 cur_last;
  logic [POS_W-1:0]     absd [AXES];
  logic [POS_W-1:0]     absd_next [AXES];
  logic [POS_W-1:0]     mag [AXES];
  logic [POS_W-1:0]     mag_next [AXES];
  logic [1:0]           axis;
  logic [SUM_W-1:0]     prod;
  logic [SUM_W-1:0]     sum_square;
  logic [SUM_W:0]       sum_wide;
  logic [COUNT_W-1:0]   particle_count;
  logic [COUNT_W-1:0]   measured_count;
  logic [COUNT_W-1:0]   measured_count_next;
  logic                 zero_count;

  logic                 ram_we;
  logic [RAM_W-1:0]     ram_rdata;
  logic [POS_W-1:0]     ref_pos [AXES];
  logic                 div_go;
  logic                 div_done;
  logic [SUM_W-1:0]     div_q;

  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign ram_we  = cmd_pop && (cmd.kind == KIND_RECORD) && cmd.in_range;
  assign div_go  = (state == S_FIN) && cur_last;

  msd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_PARTICLES),
    .AW    (AW)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(cmd.index)),
    .wdata ({cmd.pos_z, cmd.pos_y, cmd.pos_x}),
    .raddr (AW'(cmd.index)),
    .rdata (ram_rdata)
  );

  msd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (sum_square),
    .divisor  (particle_count),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ref_pos[0] = ram_rdata[POS_W-1:0];
  assign ref_pos[1] = ram_rdata[2*POS_W-1:POS_W];
  assign ref_pos[2] = ram_rdata[3*POS_W-1:2*POS_W];

  // Per-axis lanes: absolute difference, then the minimum-image fold.
  always_comb begin
    logic signed [POS_W:0] d;
    logic [POS_W:0]        t;
    for (int k = 0; k < AXES; k++) begin
      d = $signed({ref_pos[k][POS_W-1], ref_pos[k]})
        - $signed({cur_pos[k][POS_W-1], cur_pos[k]});
      absd_next[k] = d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];
      t = {1'b0, absd[k]} - {2'b0, box[k]};
      if ({absd[k], 1'b0} > {2'b0, box[k]}) begin
        mag_next[k] = t[POS_W] ? POS_W'(-t) : t[POS_W-1:0];
      end else begin
        mag_next[k] = absd[k];
      end
    end
  end

  assign sum_wide = {1'b0, sum_square} + {1'b0, prod};
  assign measured_count_next = (measured_count < COUNT_MAX) ? measured_count + 1'b1
                                                            : measured_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      sum_square     <= '0;
      particle_count <= '0;
      measured_count <= '0;
      axis           <= '0;
      for (int k = 0; k < AXES; k++) begin
        box[k] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOX_X: box[0] <= cfg_data;
          CFG_BOX_Y: box[1] <= cfg_data;
          CFG_BOX_Z: box[2] <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.kind == KIND_RECORD) begin
              if (cmd.last) begin
                particle_count <= COUNT_W'({1'b0, cmd.index} + 1'b1);
              end
            end else begin
              cur_pos[0] <= cmd.pos_x;
              cur_pos[1] <= cmd.pos_y;
              cur_pos[2] <= cmd.pos_z;
              cur_last   <= cmd.last;
              // An out-of-range slot is counted but adds nothing.
              state      <= cmd.in_range ? S_READ : S_FIN;
            end
          end
        end
        S_READ: begin
          absd  <= absd_next;
          state <= S_CORR;
        end
        S_CORR: begin
          mag   <= mag_next;
          axis  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mag[axis] * mag[axis];
          state <= S_ACC;
        end
        S_ACC: begin
          sum_square <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
          if (axis == 2'(AXES - 1)) begin
            state <= S_FIN;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (cur_last) begin
            count_mismatch <= (particle_count == '0)
                              || (measured_count_next != particle_count);
            zero_count     <= (particle_count == '0);
            // The divider captured the sum on this edge, so it can be cleared.
            sum_square     <= '0;
            measured_count <= '0;
            state          <= S_DIV;
          end else begin
            measured_count <= measured_count_next;
            state          <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            done <= 1'b1;
            if (zero_count) begin
              mean_square <= '0;
            end else if (div_q[SUM_W-1]) begin
              mean_square <= {OUT_W{1'b1}};
            end else begin
              mean_square <= div_q[OUT_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for mean_square_displacement: corner items from a table,
// then record and measure passes with random content under several box settings.
// Depends on msd_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_top;
  import msd_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam logic [BOX_W-1:0] BOX_MAX = '1;

  typedef struct {
    msd_kind_t          kind;
    logic [INDEX_W-1:0] idx;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic               last;
  } msd_item_t;

  typedef struct {
    logic [OUT_W-1:0] mean;
    logic             mismatch;
  } msd_result_t;

  typedef struct {
    msd_kind_t          kind;
    logic [INDEX_W-1:0] idx;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic               last;
    bit                 given;
    logic [OUT_W-1:0]   mean;
    logic               mm;
  } corner_row_t;

  typedef enum int {
    PASS_CLEAN,
    PASS_DROP,
    PASS_EXTRA,
    PASS_EARLY
  } pass_flaw_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 action = 1'b0;
  logic [INDEX_W-1:0]   index = '0;
  logic [POS_W-1:0]     pos_x = '0;
  logic [POS_W-1:0]     pos_y = '0;
  logic [POS_W-1:0]     pos_z = '0;
  logic                 last = 1'b0;
  logic                 done;
  logic [OUT_W-1:0]     mean_square;
  logic                 count_mismatch;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BOX_W-1:0]     cfg_data = '0;

  // Local copy of the block's state.
  logic [BOX_W-1:0]   span [AXES];
  logic [POS_W-1:0]   home_x [MSD_MAX_PARTICLES];
  logic [POS_W-1:0]   home_y [MSD_MAX_PARTICLES];
  logic [POS_W-1:0]   home_z [MSD_MAX_PARTICLES];
  bit                 filled [MSD_MAX_PARTICLES];
  logic [INDEX_W-1:0] filled_list [$];
  logic [COUNT_W-1:0] n_particles = '0;
  logic [COUNT_W-1:0] n_measured = '0;
  logic [SUM_W-1:0]   sum_sq = '0;

  msd_result_t msd_due [$];
  int sent = 0;
  int fails = 0;

  // Typed values follow from a zero box, which holds until the first write.
  corner_row_t corner_items [16] = '{
    '{KIND_RECORD,  10'd0,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
      1'b0, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd0,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
      1'b1, 63'd0, 1'b1},
    '{KIND_RECORD,  10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
      1'b0, 63'd0, 1'b0},
    '{KIND_RECORD,  10'd1,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      1'b0, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
      1'b0, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd1,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
      1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0},
    '{KIND_RECORD,  10'd0,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      1'b0, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd0,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
      1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0},
    '{KIND_MEASURE, 10'd0,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      1'b1, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd0,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
      1'b0, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd0,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      1'b1, 63'd0, 1'b1},
    '{KIND_MEASURE, 10'd0,    32'h8001_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
      1'b0, 63'd0, 1'b0},
    '{KIND_RECORD,  10'd1,    32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 1'b1,
      1'b0, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd1,    32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 1'b1,
      1'b0, 63'd0, 1'b0},
    '{KIND_RECORD,  10'd512,  32'hFFFF_FFFF, 32'h0000_0001, 32'h5A5A_5A5A, 1'b0,
      1'b0, 63'd0, 1'b0},
    '{KIND_MEASURE, 10'd512,  32'h0000_0001, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1,
      1'b0, 63'd0, 1'b0}
  };

  mean_square_displacement uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .index          (index),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .last           (last),
    .done           (done),
    .mean_square    (mean_square),
    .count_mismatch (count_mismatch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = a + b;
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // Squared minimum-image displacement on one axis, Q32.32.
  function automatic logic [SUM_W-1:0] axis_square(logic [POS_W-1:0] ref_pos,
                                                   logic [POS_W-1:0] now_pos,
                                                   logic [BOX_W-1:0] span_ax);
    longint d;
    logic [SUM_W-1:0] mag;
    d = longint'($signed(ref_pos)) - longint'($signed(now_pos));
    if (d < 0) d = -d;
    if (d * 2 > longint'({1'b0, span_ax})) d = d - longint'({1'b0, span_ax});
    mag = (d < 0) ? -d : d;
    return mag * mag;
  endfunction

  task automatic advance_msd(msd_item_t it);
    logic [SUM_W-1:0] acc;
    logic [SUM_W-1:0] q;
    msd_result_t r;
    if (it.kind == KIND_RECORD) begin
      home_x[it.idx] = it.x;
      home_y[it.idx] = it.y;
      home_z[it.idx] = it.z;
      if (!filled[it.idx]) begin
        filled[it.idx] = 1'b1;
        filled_list.push_back(it.idx);
      end
      if (it.last) n_particles = {1'b0, it.idx} + 1'b1;
    end else begin
      acc = sat_add(axis_square(home_x[it.idx], it.x, span[CFG_BOX_X]),
                    axis_square(home_y[it.idx], it.y, span[CFG_BOX_Y]));
      acc = sat_add(acc, axis_square(home_z[it.idx], it.z, span[CFG_BOX_Z]));
      sum_sq = sat_add(sum_sq, acc);
      if (n_measured != COUNT_MAX) n_measured = n_measured + 1'b1;
      if (it.last) begin
        q = (n_particles == '0) ? '0 :
            sum_sq / {{(SUM_W-COUNT_W){1'b0}}, n_particles};
        r.mean = q[SUM_W-1] ? {OUT_W{1'b1}} : q[OUT_W-1:0];
        r.mismatch = (n_particles == '0) || (n_measured != n_particles);
        msd_due.push_back(r);
        sum_sq = '0;
        n_measured = '0;
      end
    end
  endtask

  // Positions near the stored one, near half a box away, at the extremes, or anywhere.
  function automatic logic [POS_W-1:0] pick_pos(logic [POS_W-1:0] home,
                                                logic [BOX_W-1:0] span_ax);
    logic [POS_W-1:0] half;
    half = {2'b00, span_ax[BOX_W-1:1]};
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3, 4, 5: return home + $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
      6, 7: return home + half + $urandom_range(2) - 1;
      default: return home - half - $urandom_range(2) + 1;
    endcase
  endfunction

  function automatic msd_item_t make_item(msd_kind_t kind, logic [INDEX_W-1:0] slot,
                                          logic fin);
    msd_item_t it;
    it.kind = kind;
    it.idx  = slot;
    it.last = fin;
    if (kind == KIND_RECORD) begin
      it.x = pick_pos($urandom(), span[CFG_BOX_X]);
      it.y = pick_pos($urandom(), span[CFG_BOX_Y]);
      it.z = pick_pos($urandom(), span[CFG_BOX_Z]);
    end else begin
      it.x = pick_pos(home_x[slot], span[CFG_BOX_X]);
      it.y = pick_pos(home_y[slot], span[CFG_BOX_Y]);
      it.z = pick_pos(home_z[slot], span[CFG_BOX_Z]);
    end
    return it;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_filled();
    return filled_list[$urandom_range(filled_list.size() - 1)];
  endfunction

  // Starts and ends just after a falling edge.
  task automatic send(msd_item_t it, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(5, 90)) @(negedge clk);
      else repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start  <= 1'b1;
    action <= it.kind;
    index  <= it.idx;
    pos_x  <= it.x;
    pos_y  <= it.y;
    pos_z  <= it.z;
    last   <= it.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_msd(it);
    sent++;
    @(negedge clk);
  endtask

  // Records and measures not marked last cause no result, so the block may still be working.
  task automatic settle_results();
    start <= 1'b0;
    while (msd_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_box(logic [CFG_IDX_W-1:0] sel, logic [BOX_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    span[sel] = val;
    @(negedge clk);
  endtask

  task automatic set_boxes(logic [BOX_W-1:0] bx, logic [BOX_W-1:0] by,
                           logic [BOX_W-1:0] bz);
    settle_results();
    write_box(CFG_BOX_X, bx);
    write_box(CFG_BOX_Y, by);
    write_box(CFG_BOX_Z, bz);
    cfg_we <= 1'b0;
  endtask

  task automatic run_sequence(int idle_pct, int room);
    int n;
    int first;
    pass_flaw_t flaw;
    logic [INDEX_W-1:0] slot;
    case ($urandom_range(19))
      0: n = $urandom_range(65, 300);
      1, 2, 3: n = $urandom_range(13, 64);
      default: n = $urandom_range(1, 12);
    endcase
    // A record pass and up to three measure passes must fit in what is left.
    if (n > room / 4) n = (room >= 4) ? room / 4 : 1;
    for (int i = 0; i < n; i++)
      send(make_item(KIND_RECORD, INDEX_W'(i), i == n - 1), idle_pct);
    repeat ($urandom_range(1, 3)) begin
      // Mostly clean passes; some drop an item, add a stray one or close early.
      flaw = ($urandom_range(4) == 0) ? pass_flaw_t'($urandom_range(1, 3)) : PASS_CLEAN;
      first = $urandom_range(n - 1);
      for (int k = 0; k < n; k++) begin
        slot = INDEX_W'((first + k) % n);
        if (flaw == PASS_DROP && k == 0 && n > 1) continue;
        if (flaw == PASS_EXTRA && k == n - 1)
          send(make_item(KIND_MEASURE, pick_filled(), 1'b0), idle_pct);
        send(make_item(KIND_MEASURE, slot, k == n - 1 || (flaw == PASS_EARLY && k == n - 2)),
             idle_pct);
      end
    end
  endtask

  task automatic run_random(int idle_pct, int quota);
    int stop_at;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1) == 1)
          send(make_item(KIND_RECORD, INDEX_W'($urandom_range(1023)), $urandom_range(3) == 0),
               idle_pct);
        else
          send(make_item(KIND_MEASURE, pick_filled(), $urandom_range(2) == 0), idle_pct);
      end else begin
        run_sequence(idle_pct, stop_at - sent);
      end
      if ($urandom_range(29) == 0) settle_results();
    end
  endtask

  always @(posedge clk) begin : check_results
    msd_result_t want;
    if (!rst && done) begin
      if (msd_due.size() == 0) begin
        $display("%0t: unexpected result mean_square=%h count_mismatch=%b",
                 $time, mean_square, count_mismatch);
        fails++;
      end else begin
        want = msd_due.pop_front();
        if (mean_square !== want.mean) begin
          $display("%0t: mean_square expected %h got %h", $time, want.mean, mean_square);
          fails++;
        end
        if (count_mismatch !== want.mismatch) begin
          $display("%0t: count_mismatch expected %b got %b",
                   $time, want.mismatch, count_mismatch);
          fails++;
        end
      end
    end
  end

  initial begin
    msd_item_t it;
    foreach (span[a]) span[a] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 16; i++) begin
      it.kind = corner_items[i].kind;
      it.idx  = corner_items[i].idx;
      it.x    = corner_items[i].x;
      it.y    = corner_items[i].y;
      it.z    = corner_items[i].z;
      it.last = corner_items[i].last;
      send(it, 0);
      // The result waits for the divider, so the newest entry can still be replaced.
      if (corner_items[i].given)
        msd_due[msd_due.size() - 1] = '{corner_items[i].mean, corner_items[i].mm};
    end

    set_boxes(BOX_MAX, BOX_MAX, BOX_MAX);
    run_random(0, 240);
    set_boxes('0, '0, '0);
    run_random(47, 240);
    set_boxes(BOX_W'($urandom()), BOX_W'($urandom()), BOX_W'($urandom()));
    run_random(17, 240);
    set_boxes(BOX_W'($urandom_range(1, 32'h0010_0000)), BOX_W'($urandom_range(1, 32'h0010_0000)),
              BOX_W'($urandom_range(1, 32'h0010_0000)));
    run_random(0, 240);
    set_boxes(BOX_W'($urandom()), BOX_W'($urandom()), BOX_W'($urandom()));
    run_random(47, 240);
    set_boxes(BOX_MAX, '0, BOX_W'(1));
    run_random(17, 240);

    settle_results();
    if (fails == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
